FILE: hdl/dssa_pkg.sv
// dssa_pkg: widths, operation codes and reset values for the dual stack block
// no dependencies; used by dual_stack_shared_array
`default_nettype none

package dssa_pkg;

   localparam int DATA_W    = 32;
   localparam int CNT_W     = 9;
   localparam int OP_W      = 2;
   localparam int DEPTH_DEF = 256;

   localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
   localparam logic [OP_W-1:0] OP_POP  = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

   localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

   // csr map: one register, capacity, at byte address 0
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 32;
   localparam logic CSR_IDX_CAPACITY = 1'b0;

   localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

endpackage

`default_nettype wire

FILE: hdl/dssa_ram.sv
// dssa_ram: generic single-clock RAM, one write port and one registered read port
// no dependencies
`default_nettype none

module dssa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/dual_stack_shared_array.sv
// dual_stack_shared_array: two lifo stacks sharing one word store
// depends on dssa_pkg and dssa_ram
//
// Usage:
//   req channel (valid/ready) carries one operation per transfer: opcode
//   (push, pop, peek), which_stack (0 grows up from entry 0, 1 grows down
//   from entry capacity-1) and value for a push. rsp channel (valid/ready)
//   returns one result per operation, in order: data, data_valid, accepted,
//   selected_empty and store_full, the flags taken after the operation.
//   rsp_valid rises as the pending stage loads the output register. The
//   store is read at accept and its registered read word joins the result
//   in that load, so one operation per cycle is sustained while rsp_ready
//   is high; the one store access per operation sets that figure. Pushes
//   reach the store before later pops read it; no forwarding is needed.
//   When rsp_ready is low the result holds in the output register, one more
//   operation waits in the pending stage, and req_ready then drops.
//   The csr port holds capacity at byte address 0; a write empties both
//   stacks, store contents are kept. Capacity above DEPTH acts as DEPTH.
//   Reset (synchronous) empties both stacks, sets capacity to 256 and drops
//   rsp_valid; the store is not cleared and needs no clearing pass.
`default_nettype none

module dual_stack_shared_array #(
   parameter int DEPTH = dssa_pkg::DEPTH_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   // operation channel
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire [dssa_pkg::OP_W-1:0]        req_opcode,
   input  wire                             req_which_stack,
   input  wire signed [dssa_pkg::DATA_W-1:0] req_value,
   // result channel
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic signed [dssa_pkg::DATA_W-1:0] rsp_data,
   output logic                            rsp_data_valid,
   output logic                            rsp_accepted,
   output logic                            rsp_selected_empty,
   output logic                            rsp_store_full,
   // csr port
   input  wire                             csr_psel,
   input  wire                             csr_penable,
   input  wire                             csr_pwrite,
   input  wire [dssa_pkg::CSR_AW-1:0]      csr_paddr,
   input  wire [dssa_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [dssa_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                            csr_pready
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = dssa_pkg::CNT_W;
   localparam int DW = dssa_pkg::DATA_W;

   // registers
   logic [CW-1:0] capacity_ff, capacity_in;
   logic [CW-1:0] cnt_bot_ff, cnt_bot_in;
   logic [CW-1:0] cnt_top_ff, cnt_top_in;
   logic          pend_ff, pend_in;
   logic          pend_use_mem_ff;
   logic [DW-1:0] pend_data_ff;
   logic          pend_dvalid_ff, pend_acc_ff, pend_empty_ff, pend_full_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_data_ff;
   logic          rsp_dvalid_ff, rsp_acc_ff, rsp_empty_ff, rsp_full_ff;

   logic          accept, out_load, csr_wr;
   logic [CW-1:0] cap_eff, cnt_sel, addr, new_sel;
   logic [CW:0]   total, new_total;
   logic          is_push, has_room, has_item;
   logic          mem_we, mem_re;
   logic [DW-1:0] mem_rdata, early_data;
   logic          early_dvalid, early_acc;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[dssa_pkg::CSR_AW-1] == dssa_pkg::CSR_IDX_CAPACITY);
   assign csr_prdata = (csr_paddr[dssa_pkg::CSR_AW-1] == dssa_pkg::CSR_IDX_CAPACITY)
                       ? {{(dssa_pkg::CSR_DW-CW){1'b0}}, capacity_ff} : '0;

   // effective capacity saturates at the store depth
   assign cap_eff = (32'(capacity_ff) > DEPTH) ? CW'(DEPTH) : capacity_ff;

   assign out_load  = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !pend_ff || out_load;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cnt_sel   = req_which_stack ? cnt_top_ff : cnt_bot_ff;
      total     = {1'b0, cnt_bot_ff} + {1'b0, cnt_top_ff};
      is_push   = (req_opcode == dssa_pkg::OP_PUSH);
      has_room  = total < {1'b0, cap_eff};
      has_item  = cnt_sel != '0;
      cnt_bot_in = cnt_bot_ff;
      cnt_top_in = cnt_top_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      early_data   = '0;
      early_dvalid = 1'b0;
      early_acc    = 1'b0;
      if (is_push) begin
         addr = req_which_stack ? (cap_eff - 9'd1 - cnt_top_ff) : cnt_bot_ff;
      end else begin
         addr = req_which_stack ? (cap_eff - cnt_sel) : (cnt_sel - 9'd1);
      end

      case (req_opcode)
         dssa_pkg::OP_PUSH: begin
            if (has_room) begin
               mem_we    = accept;
               early_acc = 1'b1;
               if (req_which_stack) begin
                  cnt_top_in = cnt_top_ff + 9'd1;
               end else begin
                  cnt_bot_in = cnt_bot_ff + 9'd1;
               end
            end
         end
         dssa_pkg::OP_POP, dssa_pkg::OP_PEEK: begin
            if (!has_item) begin
               early_data = dssa_pkg::EMPTY_WORD;
            end else begin
               mem_re       = accept;
               early_dvalid = 1'b1;
               if (req_opcode == dssa_pkg::OP_POP) begin
                  early_acc = 1'b1;
                  if (req_which_stack) begin
                     cnt_top_in = cnt_top_ff - 9'd1;
                  end else begin
                     cnt_bot_in = cnt_bot_ff - 9'd1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      new_sel   = req_which_stack ? cnt_top_in : cnt_bot_in;
      new_total = {1'b0, cnt_bot_in} + {1'b0, cnt_top_in};
   end

   dssa_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (AW'(addr)),
      .wr_data (req_value),
      .rd_en   (mem_re),
      .rd_addr (AW'(addr)),
      .rd_data (mem_rdata)
   );

   always_comb begin
      capacity_in  = capacity_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      if (csr_wr) begin
         capacity_in = csr_pwdata[CW-1:0];
      end
      if (out_load) begin
         pend_in      = 1'b0;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= dssa_pkg::CAP_RESET;
         cnt_bot_ff   <= '0;
         cnt_top_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         // a capacity write empties both stacks
         if (csr_wr) begin
            cnt_bot_ff <= '0;
            cnt_top_ff <= '0;
         end else if (accept) begin
            cnt_bot_ff <= cnt_bot_in;
            cnt_top_ff <= cnt_top_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_use_mem_ff <= mem_re;
         pend_data_ff    <= early_data;
         pend_dvalid_ff  <= early_dvalid;
         pend_acc_ff     <= early_acc;
         pend_empty_ff   <= (new_sel == '0);
         pend_full_ff    <= (new_total >= {1'b0, cap_eff});
      end
      if (out_load) begin
         rsp_data_ff   <= pend_use_mem_ff ? mem_rdata : pend_data_ff;
         rsp_dvalid_ff <= pend_dvalid_ff;
         rsp_acc_ff    <= pend_acc_ff;
         rsp_empty_ff  <= pend_empty_ff;
         rsp_full_ff   <= pend_full_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_data_ff;
   assign rsp_data_valid     = rsp_dvalid_ff;
   assign rsp_accepted       = rsp_acc_ff;
   assign rsp_selected_empty = rsp_empty_ff;
   assign rsp_store_full     = rsp_full_ff;

endmodule

`default_nettype wire
